[hdl/asp_pkg.sv]
// ----------------------------------------------------------------------------
// asp_pkg
// Shared widths, codes and item types of the Atkin prime sieve engine.
// ----------------------------------------------------------------------------
package asp_pkg;

  // Bitmap depth and derived widths
  localparam int MAX_LIMIT = 65536;
  localparam int ADDR_W    = $clog2(MAX_LIMIT);
  localparam int LIM_W     = ADDR_W + 1;
  localparam int ROOT_W    = ADDR_W / 2 + 1;
  localparam int N_W       = LIM_W + 3;
  localparam int CNT_W     = LIM_W;
  localparam int MIN_LIMIT = 6;

  // First number that the bitmap decides on its own
  localparam int FIRST_MARK = 5;

  // Command codes
  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_QUERY   = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NO_SIEVE = 2'd2;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] number;
  } in_item_t;

  typedef struct packed {
    logic             is_prime;
    logic [CNT_W-1:0] prime_count;
    logic [1:0]       status;
  } out_item_t;

  // One access to the bitmap: one read and one write address per cycle
  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_data;
  } bm_req_t;

endpackage

[hdl/atkin_prime_sieve.sv]
// ----------------------------------------------------------------------------
// atkin_prime_sieve
// Sieve of Atkin prime engine with compute and query commands.
// ----------------------------------------------------------------------------
// Query: the bitmap bit is read when the query is accepted and the answer is
//   registered from T_QUERY; no new command is taken until the state is idle.
// Compute: steps over the bound, every toggled entry and every cleared square
//   multiple in turn (single bitmap port, shared add/compare unit).
// Reset clears control state only; queries answer status 2 until the first
//   compute, which clears the bitmap below the bound itself.
// ----------------------------------------------------------------------------
module atkin_prime_sieve import asp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LIM_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {T_IDLE, T_QUERY, T_RUN} state_e;

  state_e            state_q;
  logic [LIM_W-1:0]  limit_q;
  logic [LIM_W-1:0]  run_lim_q;
  logic              ready_q;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] number_q;
  logic              out_valid_q;
  out_item_t         out_item_q;

  logic [LIM_W-1:0] lim_eff;
  logic             in_acc;
  logic             eng_done;
  logic [CNT_W-1:0] eng_count;
  bm_req_t          eng_req, bm_req;
  logic             rd_bit;
  out_item_t        q_item;

  // Effective bound: limit clamped into the supported range
  always_comb begin
    if (limit_q < LIM_W'(MIN_LIMIT)) begin
      lim_eff = LIM_W'(MIN_LIMIT);
    end else if (limit_q > LIM_W'(MAX_LIMIT)) begin
      lim_eff = LIM_W'(MAX_LIMIT);
    end else begin
      lim_eff = limit_q;
    end
  end

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIM_W'(MAX_LIMIT);
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  assign in_stall_o = (state_q != T_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  asp_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc && (in_item_i.command == CMD_COMPUTE)),
    .lim_i    (lim_eff),
    .done_o   (eng_done),
    .count_o  (eng_count),
    .bm_req_o (eng_req),
    .rd_bit_i (rd_bit)
  );

  // Engine owns the bitmap while it runs; otherwise queries read it
  always_comb begin
    if (state_q == T_RUN) begin
      bm_req = eng_req;
    end else begin
      bm_req         = '0;
      bm_req.rd_addr = in_item_i.number;
    end
  end

  asp_bitmap u_bitmap (
    .clk_i    (clk_i),
    .req_i    (bm_req),
    .rd_bit_o (rd_bit)
  );

  // Query answer, checks in priority order
  always_comb begin
    q_item             = '0;
    q_item.prime_count = count_q;
    priority if (!ready_q) begin
      q_item.status = ST_NO_SIEVE;
    end else if ({1'b0, number_q} >= lim_eff) begin
      q_item.status = ST_RANGE;
    end else if (number_q < ADDR_W'(FIRST_MARK)) begin
      q_item.status   = ST_OK;
      q_item.is_prime = (number_q == ADDR_W'(2)) || (number_q == ADDR_W'(3));
    end else begin
      q_item.status   = ST_OK;
      q_item.is_prime = rd_bit && ({1'b0, number_q} < run_lim_q);
    end
  end

  // Control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      run_lim_q   <= '0;
      ready_q     <= 1'b0;
      count_q     <= '0;
      number_q    <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        T_IDLE: begin
          if (in_acc) begin
            number_q <= in_item_i.number;
            state_q  <= (in_item_i.command == CMD_QUERY) ? T_QUERY : T_RUN;
          end
        end
        T_QUERY: begin
          out_item_q  <= q_item;
          out_valid_q <= 1'b1;
          state_q     <= T_IDLE;
        end
        T_RUN: begin
          if (eng_done) begin
            count_q                <= eng_count;
            ready_q                <= 1'b1;
            run_lim_q              <= lim_eff;
            out_item_q.is_prime    <= 1'b0;
            out_item_q.prime_count <= eng_count;
            out_item_q.status      <= ST_OK;
            out_valid_q            <= 1'b1;
            state_q                <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A result is only loaded into an empty output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_QUERY) |-> !out_valid_q)
    else $error("query result would overwrite a pending item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_RUN) |-> !out_valid_q)
    else $error("output busy while sieve runs");

  // The engine finishes only for a compute command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_done |-> (state_q == T_RUN))
    else $error("engine done outside a compute run");

  // Once sieved, the bitmap stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |=> ready_q)
    else $error("sieve ready flag dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.status != ST_OK)) |-> !out_item_q.is_prime)
    else $error("error status with prime flag set");

endmodule

[hdl/asp_bitmap.sv]
// ----------------------------------------------------------------------------
// asp_bitmap
// Sieve bitmap, one bit per number, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module asp_bitmap import asp_pkg::*; (
  input  logic    clk_i,
  input  bm_req_t req_i,
  output logic    rd_bit_o
);

  logic mem [MAX_LIMIT];
  logic rd_bit_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_bit_q <= mem[req_i.rd_addr];
  end

  assign rd_bit_o = rd_bit_q;

endmodule

[hdl/asp_alu.sv]
// ----------------------------------------------------------------------------
// asp_alu
// Shared add/subtract unit with a bound compare on the result.
// ----------------------------------------------------------------------------
module asp_alu import asp_pkg::*; (
  input  logic [N_W-1:0] a_i,
  input  logic [N_W-1:0] b_i,
  input  logic [N_W-1:0] bound_i,
  input  logic           sub_i,
  output logic [N_W-1:0] sum_o,
  output logic           lt_o
);

  // One wide add or subtract, then compare against the bound
  assign sum_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign lt_o  = (sum_o < bound_i);

endmodule

[hdl/asp_engine.sv]
// ----------------------------------------------------------------------------
// asp_engine
// Sieve sequencer: root search, bitmap clear, quadratic toggles, square-free
// pass and prime count, all stepped through the shared add/compare unit.
// ----------------------------------------------------------------------------
module asp_engine import asp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LIM_W-1:0] lim_i,
  output logic             done_o,
  output logic [CNT_W-1:0] count_o,
  output bm_req_t          bm_req_o,
  input  logic             rd_bit_i
);

  typedef enum logic [3:0] {
    E_IDLE, E_ROOT, E_CLEAR, E_XY, E_FLIP, E_SQRD, E_SQCHK, E_SQINIT,
    E_SQCLR, E_CNT, E_CNTEND, E_DONE
  } state_e;

  // Square of a residue, mod 12
  function automatic logic [3:0] sq_mod12(input logic [3:0] r);
    logic [3:0] v;
    unique case (r)
      4'd0, 4'd6:                v = 4'd0;
      4'd1, 4'd5, 4'd7, 4'd11:   v = 4'd1;
      4'd2, 4'd4, 4'd8, 4'd10:   v = 4'd4;
      4'd3, 4'd9:                v = 4'd9;
      default:                   v = 4'd0;
    endcase
    return v;
  endfunction

  // Small value mod 12 by repeated compare and subtract
  function automatic logic [3:0] mod12(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    for (int i = 0; i < 4; i++) begin
      if (t >= 6'd12) t = t - 6'd12;
    end
    return t[3:0];
  endfunction

  state_e            state_q;
  logic [LIM_W-1:0]  lim_q;
  logic [ROOT_W-1:0] root_q;
  logic [N_W-1:0]    sq_q;
  logic [ROOT_W-1:0] x_q, y_q, sn_q;
  logic [3:0]        x12_q, y12_q;
  logic [N_W-1:0]    x3_q, x4_q, yy_q;
  logic [1:0]        k_q;
  logic [N_W-1:0]    n_q, a_q, m_q;
  logic              m_ok_q;
  logic              pend_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [N_W-1:0]      alu_a, alu_b, alu_sum;
  logic                alu_sub, alu_lt;
  logic [3:0]          rx, ry, r4, r3, r3m;
  logic                match, qualify;
  logic                step_xy, step_sn;
  logic [2*ROOT_W-1:0] sq_prod;
  logic [N_W-1:0]      lim_ext;

  assign lim_ext = N_W'(lim_q);
  assign sq_prod = sn_q * sn_q;

  // Residues of the candidates mod 12
  assign rx  = sq_mod12(x12_q);
  assign ry  = sq_mod12(y12_q);
  assign r4  = mod12({rx, 2'b00} + {2'b00, ry});
  assign r3  = mod12({1'b0, rx, 1'b0} + {2'b00, rx} + {2'b00, ry});
  assign r3m = mod12({1'b0, rx, 1'b0} + {2'b00, rx} + 6'd12 - {2'b00, ry});

  always_comb begin
    unique case (k_q)
      2'd0:    match = (r4 == 4'd1) || (r4 == 4'd5);
      2'd1:    match = (r3 == 4'd7);
      default: match = (r3m == 4'd11) && (x_q > y_q);
    endcase
  end

  assign qualify = alu_lt && match;
  assign step_xy = ((state_q == E_XY) && !qualify) || (state_q == E_FLIP);
  assign step_sn = ((state_q == E_SQCHK) && !rd_bit_i) ||
                   ((state_q == E_SQCLR) && !m_ok_q);

  // Operand select for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      E_ROOT: begin
        alu_a = lim_ext;
      end
      E_CLEAR, E_CNT: begin
        alu_a = a_q;
        alu_b = N_W'(1);
      end
      E_XY: begin
        alu_a   = (k_q == 2'd0) ? x4_q : x3_q;
        alu_b   = yy_q;
        alu_sub = (k_q == 2'd2);
      end
      E_SQINIT: begin
        alu_a = sq_q;
      end
      E_SQCLR: begin
        alu_a = m_q;
        alu_b = sq_q;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // Root search compares the limit against the running square
  asp_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .bound_i ((state_q == E_ROOT) ? sq_q : lim_ext),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .lt_o    (alu_lt)
  );

  // Bitmap access of each state
  always_comb begin
    bm_req_o = '0;
    unique case (state_q)
      E_CLEAR: begin
        bm_req_o.we      = 1'b1;
        bm_req_o.wr_addr = a_q[ADDR_W-1:0];
        bm_req_o.wr_data = 1'b0;
      end
      E_XY: begin
        bm_req_o.rd_addr = alu_sum[ADDR_W-1:0];
      end
      E_FLIP: begin
        bm_req_o.we      = 1'b1;
        bm_req_o.wr_addr = n_q[ADDR_W-1:0];
        bm_req_o.wr_data = ~rd_bit_i;
      end
      E_SQRD: begin
        bm_req_o.rd_addr = ADDR_W'(sn_q);
      end
      E_SQCLR: begin
        bm_req_o.we      = m_ok_q;
        bm_req_o.wr_addr = m_q[ADDR_W-1:0];
        bm_req_o.wr_data = 1'b0;
      end
      E_CNT: begin
        bm_req_o.rd_addr = a_q[ADDR_W-1:0];
      end
      default: begin
        bm_req_o.we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      lim_q   <= '0;
      root_q  <= '0;
      sq_q    <= '0;
      x_q     <= '0;
      y_q     <= '0;
      sn_q    <= '0;
      x12_q   <= '0;
      y12_q   <= '0;
      x3_q    <= '0;
      x4_q    <= '0;
      yy_q    <= '0;
      k_q     <= '0;
      n_q     <= '0;
      a_q     <= '0;
      m_q     <= '0;
      m_ok_q  <= 1'b0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      pend_q <= (state_q == E_CNT);
      if (pend_q && rd_bit_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end

      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            lim_q   <= lim_i;
            root_q  <= '0;
            sq_q    <= N_W'(1);
            state_q <= E_ROOT;
          end
        end
        // Grow the root while (root+1)^2 does not exceed the limit
        E_ROOT: begin
          if (alu_lt) begin
            a_q     <= '0;
            state_q <= E_CLEAR;
          end else begin
            root_q <= root_q + ROOT_W'(1);
            sq_q   <= sq_q + N_W'({root_q, 1'b0}) + N_W'(3);
          end
        end
        // Zero every entry below the limit
        E_CLEAR: begin
          if (alu_lt) begin
            a_q <= alu_sum;
          end else begin
            x_q     <= '0;
            y_q     <= '0;
            x12_q   <= '0;
            y12_q   <= '0;
            x3_q    <= '0;
            x4_q    <= '0;
            yy_q    <= '0;
            k_q     <= '0;
            state_q <= E_XY;
          end
        end
        E_XY: begin
          if (qualify) begin
            n_q     <= alu_sum;
            state_q <= E_FLIP;
          end
        end
        // The loop step below picks the next state
        E_FLIP: begin
        end
        E_SQRD: begin
          state_q <= E_SQCHK;
        end
        E_SQCHK: begin
          if (rd_bit_i) begin
            sq_q    <= N_W'(sq_prod);
            state_q <= E_SQINIT;
          end
        end
        E_SQINIT: begin
          m_q     <= alu_sum;
          m_ok_q  <= alu_lt;
          state_q <= E_SQCLR;
        end
        E_SQCLR: begin
          if (m_ok_q) begin
            m_q    <= alu_sum;
            m_ok_q <= alu_lt;
          end
        end
        E_CNT: begin
          if (alu_lt) begin
            a_q <= alu_sum;
          end else begin
            state_q <= E_CNTEND;
          end
        end
        E_CNTEND: begin
          state_q <= E_DONE;
        end
        E_DONE: begin
          state_q <= E_IDLE;
        end
        default: begin
          state_q <= E_IDLE;
        end
      endcase

      // Advance candidate, then y, then x of the quadratic pass
      if (step_xy) begin
        if (k_q != 2'd2) begin
          k_q     <= k_q + 2'd1;
          state_q <= E_XY;
        end else begin
          k_q <= '0;
          if (y_q == root_q) begin
            y_q   <= '0;
            y12_q <= '0;
            yy_q  <= '0;
            if (x_q == root_q) begin
              if (root_q < ROOT_W'(FIRST_MARK)) begin
                a_q     <= N_W'(FIRST_MARK);
                cnt_q   <= CNT_W'(2);
                state_q <= E_CNT;
              end else begin
                sn_q    <= ROOT_W'(FIRST_MARK);
                state_q <= E_SQRD;
              end
            end else begin
              x_q     <= x_q + ROOT_W'(1);
              x12_q   <= (x12_q == 4'd11) ? 4'd0 : x12_q + 4'd1;
              x3_q    <= x3_q + N_W'({x_q, 2'b00}) + N_W'({x_q, 1'b0}) + N_W'(3);
              x4_q    <= x4_q + N_W'({x_q, 3'b000}) + N_W'(4);
              state_q <= E_XY;
            end
          end else begin
            y_q     <= y_q + ROOT_W'(1);
            y12_q   <= (y12_q == 4'd11) ? 4'd0 : y12_q + 4'd1;
            yy_q    <= yy_q + N_W'({y_q, 1'b0}) + N_W'(1);
            state_q <= E_XY;
          end
        end
      end

      // Advance to the next square candidate or start the count
      if (step_sn) begin
        if (sn_q == root_q) begin
          a_q     <= N_W'(FIRST_MARK);
          cnt_q   <= CNT_W'(2);
          state_q <= E_CNT;
        end else begin
          sn_q    <= sn_q + ROOT_W'(1);
          state_q <= E_SQRD;
        end
      end
    end
  end

  assign done_o  = (state_q == E_DONE);
  assign count_o = cnt_q;

endmodule
